/* rtl/efar_pkg.sv */
package efar_pkg;

    localparam int COUNTS_PER_REV      = 4000;
    localparam int FRAME_PAYLOAD_BYTES = 8;

    localparam logic [7:0] SYNC_BYTE = 8'hFF;

    localparam int POS_W  = 4;
    localparam int BIDX_W = $clog2(FRAME_PAYLOAD_BYTES);

    localparam int REM_W = $clog2(COUNTS_PER_REV);
    localparam int MAG_W = $clog2(6 * COUNTS_PER_REV + 1);

    localparam int ANG_X_W = 34;
    localparam longint unsigned BIAS_L =
        (((64'd1 << 32) + COUNTS_PER_REV - 1) / COUNTS_PER_REV) * COUNTS_PER_REV;
    localparam logic [ANG_X_W-1:0] ANG_BIAS = ANG_X_W'(BIAS_L);

    localparam int K_W = 35;
    localparam logic [K_W-1:0] TWO_PI_Q32 = 35'd26986075409;
    localparam int PROD_W    = MAG_W + K_W;
    localparam int NUM_W     = PROD_W + 2;
    localparam int RND_SHIFT = 21;
    localparam logic [NUM_W-1:0] RND_ADD = NUM_W'(COUNTS_PER_REV) << (RND_SHIFT - 1);

    localparam int DIV_NEED   = (ANG_X_W > NUM_W - RND_SHIFT) ? ANG_X_W : NUM_W - RND_SHIFT;
    localparam int DIV_STEPS  = 8;
    localparam int DIV_STAGES = (DIV_NEED + DIV_STEPS - 1) / DIV_STEPS;
    localparam int DIV_W      = DIV_STAGES * DIV_STEPS;

    localparam logic [REM_W:0] CPR_V = (REM_W + 1)'(COUNTS_PER_REV);

    localparam logic [31:0] VEL_LIMIT   = 32'(6 * COUNTS_PER_REV);
    localparam logic [18:0] VEL_SAT_Q12 = 19'd154416;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [31:0] angle;
        logic [31:0] vel;
    } t_frame;

endpackage

/* rtl/encoder_frame_angle_reader_unit.sv */
// Encoder frame reader: takes one serial byte per cycle, drops bytes until a
// 0xFF sync byte, then gathers the next 8 bytes as two little-endian signed
// words (angle, velocity) and emits one result per frame: the angle less the
// configured offset, wrapped to one revolution (0..3999) and about the bottom
// (-2000..1999), the angle in Q3.12 radians, the raw velocity, and the velocity
// in Q7.12 radians per second saturated at 12 pi with a clip flag. Sync values
// inside a frame are data. After the last byte of a frame is taken, the frame
// passes through a two-entry queue, then runs a 14-stage pipeline (three
// 5-stage divide-by-4000 units in two rounds, with the multiplies between
// them), and sits in an output register. Bytes are taken every cycle while
// the queue has room; the math pipeline takes a new frame every cycle unless
// the output is stalled, so the frame length of 9 bytes sets the result rate.
// Write the offset only while no frame is in flight.
module encoder_frame_angle_reader_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [31:0]        i_cfg_wdata,
    input  logic               i_rx_valid,
    output logic               o_rx_ready,
    input  logic [7:0]         i_rx_byte,
    output logic               o_res_valid,
    input  logic               i_res_ready,
    output logic signed [11:0] o_angle_counts,
    output logic [11:0]        o_angle_from_bottom,
    output logic signed [14:0] o_angle_rad_q,
    output logic signed [31:0] o_velocity_counts,
    output logic signed [18:0] o_velocity_rad_q,
    output logic               o_velocity_clipped
);
    import efar_pkg::*;

    logic   push;
    logic   q_full;
    logic   q_valid;
    logic   pop;
    t_frame push_frame;
    t_frame q_frame;

    efar_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rx_valid (i_rx_valid),
        .i_rx_byte  (i_rx_byte),
        .o_rx_ready (o_rx_ready),
        .i_q_full   (q_full),
        .o_push     (push),
        .o_frame    (push_frame)
    );

    efar_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_frame),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (q_frame),
        .i_pop   (pop)
    );

    efar_back u_back (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_wdata         (i_cfg_wdata),
        .i_q_valid           (q_valid),
        .i_frame             (q_frame),
        .o_pop               (pop),
        .i_res_ready         (i_res_ready),
        .o_res_valid         (o_res_valid),
        .o_angle_counts      (o_angle_counts),
        .o_angle_from_bottom (o_angle_from_bottom),
        .o_angle_rad_q       (o_angle_rad_q),
        .o_velocity_counts   (o_velocity_counts),
        .o_velocity_rad_q    (o_velocity_rad_q),
        .o_velocity_clipped  (o_velocity_clipped)
    );

endmodule

/* rtl/efar_front.sv */
module efar_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_rx_valid,
    input  logic [7:0]       i_rx_byte,
    output logic             o_rx_ready,
    input  logic             i_q_full,
    output logic             o_push,
    output efar_pkg::t_frame o_frame
);
    import efar_pkg::*;

    localparam logic [POS_W-1:0] POS_HUNT = '0;
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(FRAME_PAYLOAD_BYTES);

    logic [POS_W-1:0]                     r_pos;
    logic [POS_W-1:0]                     n_pos;
    logic [8*(FRAME_PAYLOAD_BYTES-1)-1:0] r_bytes;
    logic                                 accept;
    logic                                 hunting;
    logic [BIDX_W-1:0]                    bidx;

    assign hunting    = (r_pos == POS_HUNT) || (r_pos > POS_LAST);
    assign o_rx_ready = !((r_pos == POS_LAST) && i_q_full);
    assign accept     = i_rx_valid && o_rx_ready;
    assign bidx       = BIDX_W'(r_pos - 1'b1);
    assign o_push     = accept && (r_pos == POS_LAST);

    assign o_frame.angle = r_bytes[31:0];
    assign o_frame.vel   = {i_rx_byte, r_bytes[55:32]};

    always_comb begin
        n_pos = r_pos;
        if (accept) begin
            if (hunting) begin
                n_pos = (i_rx_byte == SYNC_BYTE) ? POS_W'(1) : POS_HUNT;
            end else if (r_pos == POS_LAST) begin
                n_pos = POS_HUNT;
            end else begin
                n_pos = r_pos + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= POS_HUNT;
        end else begin
            r_pos <= n_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && !hunting && (r_pos != POS_LAST)) begin
            r_bytes[8*bidx +: 8] <= i_rx_byte;
        end
    end

endmodule

/* rtl/efar_queue.sv */
module efar_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  efar_pkg::t_frame i_data,
    output logic             o_full,
    output logic             o_valid,
    output efar_pkg::t_frame o_data,
    input  logic             i_pop
);
    import efar_pkg::*;

    t_frame            r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wp;
    logic [QPTR_W-1:0] r_rp;
    logic [QCNT_W-1:0] r_cnt;

    assign o_full  = (r_cnt == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + QCNT_W'(i_push) - QCNT_W'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

/* rtl/efar_cdiv.sv */
module efar_cdiv (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic [efar_pkg::DIV_W-1:0] i_num,
    output logic [efar_pkg::DIV_W-1:0] o_quo,
    output logic [efar_pkg::REM_W-1:0] o_rem
);
    import efar_pkg::*;

    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [DIV_W-1:0] work;
    } t_div;

    t_div r_st [DIV_STAGES];
    t_div n_st [DIV_STAGES];

    function automatic t_div div_steps(t_div s);
        t_div           t;
        logic [REM_W:0] r2;
        t = s;
        for (int k = 0; k < DIV_STEPS; k++) begin
            r2 = {t.rem, t.work[DIV_W-1]};
            if (r2 >= CPR_V) begin
                t.rem  = REM_W'(r2 - CPR_V);
                t.work = {t.work[DIV_W-2:0], 1'b1};
            end else begin
                t.rem  = r2[REM_W-1:0];
                t.work = {t.work[DIV_W-2:0], 1'b0};
            end
        end
        return t;
    endfunction

    always_comb begin
        n_st[0] = div_steps({{REM_W{1'b0}}, i_num});
        for (int s = 1; s < DIV_STAGES; s++) begin
            n_st[s] = div_steps(r_st[s-1]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int s = 0; s < DIV_STAGES; s++) begin
                r_st[s] <= n_st[s];
            end
        end
    end

    assign o_quo = r_st[DIV_STAGES-1].work;
    assign o_rem = r_st[DIV_STAGES-1].rem;

endmodule

/* rtl/efar_back.sv */
module efar_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [31:0]        i_cfg_wdata,
    input  logic               i_q_valid,
    input  efar_pkg::t_frame   i_frame,
    output logic               o_pop,
    input  logic               i_res_ready,
    output logic               o_res_valid,
    output logic signed [11:0] o_angle_counts,
    output logic [11:0]        o_angle_from_bottom,
    output logic signed [14:0] o_angle_rad_q,
    output logic signed [31:0] o_velocity_counts,
    output logic signed [18:0] o_velocity_rad_q,
    output logic               o_velocity_clipped
);
    import efar_pkg::*;

    localparam int NSTG = 2 * DIV_STAGES + 4;
    localparam logic [REM_W-1:0] HALF_UP =
        REM_W'(COUNTS_PER_REV - COUNTS_PER_REV / 2);

    typedef struct packed {
        logic [31:0]      vraw;
        logic [MAG_W-1:0] vmag;
        logic             vneg;
        logic             vclip;
    } t_vside;

    typedef struct packed {
        logic [REM_W-1:0] bottom;
        logic [REM_W:0]   sang;
        logic             aneg;
        logic [31:0]      vraw;
        logic             vneg;
        logic             vclip;
    } t_side;

    logic                en;
    logic [NSTG-1:0]     r_vld;
    logic [ANG_X_W-1:0]  r_off_adj;

    logic [31:0]         vmag_full;
    t_vside              n_e_v;
    logic [ANG_X_W-1:0]  r_e_x;
    t_vside              r_e_v;
    t_vside              r_dv [DIV_STAGES];

    logic [REM_W-1:0]    a_rem;
    logic                lt;
    t_side               n_g_side;
    t_side               r_g_side;
    logic [MAG_W-1:0]    r_g_amag;
    logic [MAG_W-1:0]    r_g_vmag;

    logic [PROD_W-1:0]   r_p_aprod;
    logic [PROD_W-1:0]   r_p_vprod;
    t_side               r_p_side;

    logic [NUM_W-1:0]    n_asum;
    logic [NUM_W-1:0]    n_vsum;
    logic [DIV_W-1:0]    r_n_anum;
    logic [DIV_W-1:0]    r_n_vnum;
    t_side               r_n_side;

    logic [DIV_W-1:0]    aq;
    logic [DIV_W-1:0]    vq;
    t_side               r_dr [DIV_STAGES];
    t_side               fin;

    logic                r_out_valid;

    assign en    = !r_out_valid || i_res_ready;
    assign o_pop = i_q_valid && en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_off_adj <= ANG_BIAS;
        end else if (i_cfg_we) begin
            r_off_adj <= ANG_BIAS - {{(ANG_X_W-32){i_cfg_wdata[31]}}, i_cfg_wdata};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_vld       <= {r_vld[NSTG-2:0], o_pop};
            r_out_valid <= r_vld[NSTG-1];
        end
    end

    // entry: bias the angle, take the velocity magnitude
    always_comb begin
        vmag_full   = i_frame.vel[31] ? (~i_frame.vel + 32'd1) : i_frame.vel;
        n_e_v.vraw  = i_frame.vel;
        n_e_v.vmag  = MAG_W'(vmag_full);
        n_e_v.vneg  = i_frame.vel[31];
        n_e_v.vclip = vmag_full > VEL_LIMIT;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_e_x <= {{(ANG_X_W-32){i_frame.angle[31]}}, i_frame.angle} + r_off_adj;
            r_e_v <= n_e_v;
            r_dv[0] <= r_e_v;
            for (int s = 1; s < DIV_STAGES; s++) begin
                r_dv[s] <= r_dv[s-1];
            end
        end
    end

    efar_cdiv u_div_ang (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (DIV_W'(r_e_x)),
        .o_quo (),
        .o_rem (a_rem)
    );

    // fold the wrapped angle about the bottom
    always_comb begin
        lt               = a_rem < HALF_UP;
        n_g_side.bottom  = a_rem;
        n_g_side.sang    = lt ? {1'b0, a_rem} : {1'b0, a_rem} - CPR_V;
        n_g_side.aneg    = !lt;
        n_g_side.vraw    = r_dv[DIV_STAGES-1].vraw;
        n_g_side.vneg    = r_dv[DIV_STAGES-1].vneg;
        n_g_side.vclip   = r_dv[DIV_STAGES-1].vclip;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_g_side <= n_g_side;
            r_g_amag <= lt ? MAG_W'(a_rem) : MAG_W'(CPR_V - {1'b0, a_rem});
            r_g_vmag <= r_dv[DIV_STAGES-1].vmag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p_aprod <= r_g_amag * TWO_PI_Q32;
            r_p_vprod <= r_g_vmag * TWO_PI_Q32;
            r_p_side  <= r_g_side;
        end
    end

    assign n_asum = NUM_W'({r_p_aprod, 1'b0}) + RND_ADD;
    assign n_vsum = NUM_W'({r_p_vprod, 1'b0}) + RND_ADD;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_n_anum <= DIV_W'(n_asum[NUM_W-1:RND_SHIFT]);
            r_n_vnum <= DIV_W'(n_vsum[NUM_W-1:RND_SHIFT]);
            r_n_side <= r_p_side;
            r_dr[0]  <= r_n_side;
            for (int s = 1; s < DIV_STAGES; s++) begin
                r_dr[s] <= r_dr[s-1];
            end
        end
    end

    efar_cdiv u_div_arad (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (r_n_anum),
        .o_quo (aq),
        .o_rem ()
    );

    efar_cdiv u_div_vrad (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (r_n_vnum),
        .o_quo (vq),
        .o_rem ()
    );

    assign fin = r_dr[DIV_STAGES-1];

    always_ff @(posedge i_clk) begin
        if (en && r_vld[NSTG-1]) begin
            o_angle_counts      <= 12'($signed(fin.sang));
            o_angle_from_bottom <= 12'(fin.bottom);
            o_angle_rad_q       <= fin.aneg ? 15'(-aq) : 15'(aq);
            o_velocity_counts   <= fin.vraw;
            o_velocity_clipped  <= fin.vclip;
            if (fin.vclip) begin
                o_velocity_rad_q <= fin.vneg ? 19'(-VEL_SAT_Q12) : VEL_SAT_Q12;
            end else begin
                o_velocity_rad_q <= fin.vneg ? 19'(-vq) : 19'(vq);
            end
        end
    end

    assign o_res_valid = r_out_valid;

endmodule

/* rtl/efar_chk.sv */
module efar_chk (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_res_valid,
    input logic               i_res_ready,
    input logic signed [11:0] o_angle_counts,
    input logic [11:0]        o_angle_from_bottom,
    input logic signed [14:0] o_angle_rad_q,
    input logic signed [31:0] o_velocity_counts,
    input logic signed [18:0] o_velocity_rad_q,
    input logic               o_velocity_clipped
);
    import efar_pkg::*;

    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && !i_res_ready |=> o_res_valid && $stable(o_angle_counts)
            && $stable(o_angle_rad_q) && $stable(o_velocity_rad_q)
            && $stable(o_velocity_counts))
        else $error("result changed while stalled");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_res_valid)
        else $error("result valid after reset");

    a_clip_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_velocity_clipped |->
            ($unsigned(o_velocity_rad_q) == VEL_SAT_Q12)
            || ($unsigned(o_velocity_rad_q) == 19'(-VEL_SAT_Q12)))
        else $error("clipped velocity not at limit");

    a_vel_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && !o_velocity_clipped |->
            !o_velocity_rad_q[18] || o_velocity_counts[31])
        else $error("velocity sign flipped");

    a_angle_fold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |->
            ($unsigned(o_angle_counts) == o_angle_from_bottom)
            || ($unsigned(o_angle_counts)
                == 12'(o_angle_from_bottom - 12'(COUNTS_PER_REV))))
        else $error("angle views disagree");

endmodule

bind encoder_frame_angle_reader_unit efar_chk u_chk (.*);

/* dv/encoder_frame_angle_reader_unit_test.sv */
`timescale 1ns / 100ps

module encoder_frame_angle_reader_unit_test;
    import efar_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 20;

    typedef struct packed {
        logic [11:0] angle_counts;
        logic [11:0] angle_from_bottom;
        logic [14:0] angle_rad_q;
        logic [31:0] velocity_counts;
        logic [18:0] velocity_rad_q;
        logic        velocity_clipped;
    } t_frame_result;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [31:0]        i_cfg_wdata = '0;
    logic               i_rx_valid = 1'b0;
    logic               o_rx_ready;
    logic [7:0]         i_rx_byte = '0;
    logic               o_res_valid;
    logic               i_res_ready = 1'b0;
    logic signed [11:0] o_angle_counts;
    logic [11:0]        o_angle_from_bottom;
    logic signed [14:0] o_angle_rad_q;
    logic signed [31:0] o_velocity_counts;
    logic signed [18:0] o_velocity_rad_q;
    logic               o_velocity_clipped;

    encoder_frame_angle_reader_unit dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_wdata         (i_cfg_wdata),
        .i_rx_valid          (i_rx_valid),
        .o_rx_ready          (o_rx_ready),
        .i_rx_byte           (i_rx_byte),
        .o_res_valid         (o_res_valid),
        .i_res_ready         (i_res_ready),
        .o_angle_counts      (o_angle_counts),
        .o_angle_from_bottom (o_angle_from_bottom),
        .o_angle_rad_q       (o_angle_rad_q),
        .o_velocity_counts   (o_velocity_counts),
        .o_velocity_rad_q    (o_velocity_rad_q),
        .o_velocity_clipped  (o_velocity_clipped)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    logic [7:0]    byte_backlog[$];
    t_frame_result pending_results[$];

    function automatic void append_byte(input logic [7:0] b);
        byte_backlog = {byte_backlog, b};
    endfunction

    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          active_phase = -1;
    logic        hold_off = 1'b0;
    int          mismatches = 0;
    int unsigned cycle_count = 0;

    // frame tracking for the expected results
    int          frame_pos = 0;
    logic [63:0] payload = '0;
    logic [31:0] count_offset = '0;

    function automatic longint to_radians_q12(input longint x);
        longint unsigned mag;
        longint unsigned num;
        longint unsigned den;
        longint unsigned q;
        mag = (x < 0) ? longint'(-x) : longint'(x);
        num = mag * longint'(TWO_PI_Q32);
        den = longint'(COUNTS_PER_REV) << 20;
        q = (2 * num + den) / (2 * den);
        if (x < 0)
            return -longint'(q);
        return longint'(q);
    endfunction

    function automatic t_frame_result convert_frame(input logic [63:0] bytes,
                                                    input logic [31:0] offset);
        longint cpr;
        longint half;
        longint a;
        longint bottom;
        longint wrapped;
        longint vel;
        longint vmag;
        longint vrad;
        longint arad;
        logic clip;
        t_frame_result r;
        cpr = COUNTS_PER_REV;
        half = cpr / 2;
        a = longint'($signed(bytes[31:0])) - longint'($signed(offset));
        bottom = ((a % cpr) + cpr) % cpr;
        wrapped = (((a + half) % cpr) + cpr) % cpr - half;
        vel = longint'($signed(bytes[63:32]));
        vmag = (vel < 0) ? -vel : vel;
        clip = (vmag > 6 * cpr);
        if (clip) begin
            vrad = (vel < 0) ? -longint'(VEL_SAT_Q12) : longint'(VEL_SAT_Q12);
        end else begin
            vrad = to_radians_q12(vel);
        end
        arad = to_radians_q12(wrapped);
        r.angle_counts = wrapped[11:0];
        r.angle_from_bottom = bottom[11:0];
        r.angle_rad_q = arad[14:0];
        r.velocity_counts = bytes[63:32];
        r.velocity_rad_q = vrad[18:0];
        r.velocity_clipped = clip;
        return r;
    endfunction

    task automatic take_byte(input logic [7:0] b);
        if (frame_pos == 0) begin
            frame_pos = (b == SYNC_BYTE) ? 1 : 0;
        end else begin
            payload[8 * (frame_pos - 1) +: 8] = b;
            if (frame_pos < FRAME_PAYLOAD_BYTES) begin
                frame_pos++;
            end else begin
                frame_pos = 0;
                pending_results = {pending_results, convert_frame(payload, count_offset)};
            end
        end
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_rx_valid <= 1'b0;
        end else begin
            if (i_rx_valid && o_rx_ready)
                take_byte(i_rx_byte);
            if (!i_rx_valid || o_rx_ready) begin
                if (byte_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    i_rx_valid <= 1'b1;
                    i_rx_byte <= byte_backlog.pop_front();
                end else begin
                    i_rx_valid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            mismatches++;
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        end
    endtask

    // monitor
    always @(posedge i_clk) begin : monitor
        t_frame_result want;
        if (!i_rst_n) begin
            i_res_ready <= 1'b0;
        end else begin
            if (o_res_valid && i_res_ready) begin
                if (pending_results.size() == 0) begin
                    mismatches++;
                    $error("result with no frame pending");
                end else begin
                    want = pending_results.pop_front();
                    check_field("angle_counts", 32'(want.angle_counts),
                                32'($unsigned(o_angle_counts)));
                    check_field("angle_from_bottom", 32'(want.angle_from_bottom),
                                32'(o_angle_from_bottom));
                    check_field("angle_rad_q", 32'(want.angle_rad_q),
                                32'($unsigned(o_angle_rad_q)));
                    check_field("velocity_counts", want.velocity_counts, o_velocity_counts);
                    check_field("velocity_rad_q", 32'(want.velocity_rad_q),
                                32'($unsigned(o_velocity_rad_q)));
                    check_field("velocity_clipped", 32'(want.velocity_clipped),
                                32'(o_velocity_clipped));
                end
            end
            i_res_ready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // long receiver stall during the last phase
    initial begin
        wait (active_phase == 5);
        repeat (20) @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (300) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic queue_frame(input logic [31:0] angle, input logic [31:0] vel);
        append_byte(SYNC_BYTE);
        for (int i = 0; i < 4; i++)
            append_byte(angle[8 * i +: 8]);
        for (int i = 0; i < 4; i++)
            append_byte(vel[8 * i +: 8]);
    endtask

    // close any open frame, then drop back to hunting
    task automatic queue_flush();
        repeat (FRAME_PAYLOAD_BYTES + 1)
            append_byte(8'($urandom_range(0, 254)));
    endtask

    function automatic logic [31:0] pick_angle(input logic [31:0] off);
        logic [31:0] v;
        case ($urandom_range(3))
            0: v = $urandom;
            1: v = off + $urandom_range(0, 8200) - 32'd4100;
            2: v = off + 32'd2000 * $urandom_range(0, 4) - 32'd4000 + $urandom_range(0, 2) - 1;
            default: v = $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
        endcase
        return v;
    endfunction

    function automatic logic [31:0] pick_velocity();
        logic [31:0] v;
        case ($urandom_range(4))
            0: v = $urandom;
            1: v = $urandom_range(0, 48000) - 32'd24000;
            2: begin
                case ($urandom_range(3))
                    0: v = 32'd24000;
                    1: v = 32'd24001;
                    2: v = 32'(-24000);
                    default: v = 32'(-24001);
                endcase
            end
            3: v = $urandom_range(0, 600) - 32'd300;
            default: begin
                case ($urandom_range(2))
                    0: v = 32'h8000_0000;
                    1: v = 32'h7FFF_FFFF;
                    default: v = 32'hFFFF_FFFF;
                endcase
            end
        endcase
        return v;
    endfunction

    task automatic queue_traffic(input int n_bytes, input logic [31:0] off);
        int start;
        int pick;
        start = byte_backlog.size();
        while (byte_backlog.size() - start < n_bytes) begin
            pick = $urandom_range(99);
            if (pick < 80) begin
                queue_frame(pick_angle(off), pick_velocity());
            end else if (pick < 92) begin
                repeat ($urandom_range(1, 4))
                    append_byte(8'($urandom));
            end else begin
                append_byte(SYNC_BYTE);
                repeat ($urandom_range(1, 7))
                    append_byte(8'($urandom));
            end
        end
        queue_flush();
    endtask

    task automatic wait_idle();
        while (byte_backlog.size() != 0 || i_rx_valid || pending_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic load_offset(input logic [31:0] v);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        count_offset = v;
    endtask

    initial begin : stimulus
        logic [31:0] offsets[6];
        offsets = '{32'd0, 32'h8000_0000, 32'h7FFF_FFFF, 32'd0, 32'hFFFF_FFFF, 32'd1234};
        offsets[3] = $urandom;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // hunting drops non-sync bytes; sync values inside payload are data
        append_byte(8'h00);
        append_byte(8'hFE);
        queue_frame(32'hFFFF_FFFF, 32'h7FFF_FFFF);
        queue_frame(32'h8000_0000, 32'h8000_0000);
        queue_frame(32'd2000, 32'd24000);

        for (int ph = 0; ph < 6; ph++) begin
            case (ph / 2)
                0: begin
                    send_idle_pct <= 38;
                    recv_idle_pct <= 62;
                end
                1: begin
                    send_idle_pct <= 62;
                    recv_idle_pct <= 38;
                end
                default: begin
                    send_idle_pct <= 0;
                    recv_idle_pct <= 0;
                end
            endcase
            if (ph > 0)
                load_offset(offsets[ph]);
            active_phase <= ph;
            queue_traffic((ph == 5) ? 280 : 190, offsets[ph]);
            wait_idle();
        end

        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

/* encoder_frame_angle_reader_unit.f */
rtl/efar_pkg.sv
rtl/efar_front.sv
rtl/efar_queue.sv
rtl/efar_cdiv.sv
rtl/efar_back.sv
rtl/encoder_frame_angle_reader_unit.sv
rtl/efar_chk.sv
dv/encoder_frame_angle_reader_unit_test.sv
